// ----- hdl/bgc_pkg.sv -----
// Package for the button gesture classifier: event codes, register indexes,
// register reset values and the configuration struct.
// No dependencies; imported by the configuration bank, the core and the top level.
package bgc_pkg;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvSingle = 2'd1,
    EvLong   = 2'd2,
    EvDouble = 2'd3
  } key_event_e;

  localparam int unsigned CfgIdxWidth  = 4;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned ThreshWidth  = 16;

  localparam logic [CfgIdxWidth-1:0] RegEnable        = 4'd0;
  localparam logic [CfgIdxWidth-1:0] RegLongPress     = 4'd1;
  localparam logic [CfgIdxWidth-1:0] RegDoubleClick   = 4'd2;
  localparam logic [CfgIdxWidth-1:0] RegSingleTimeout = 4'd3;

  localparam logic [ThreshWidth-1:0] LongPressReset     = 16'd2000;
  localparam logic [ThreshWidth-1:0] DoubleClickReset   = 16'd300;
  localparam logic [ThreshWidth-1:0] SingleTimeoutReset = 16'd500;

  typedef struct packed {
    logic                   enable;
    logic [ThreshWidth-1:0] long_press_ticks;
    logic [ThreshWidth-1:0] double_click_ticks;
    logic [ThreshWidth-1:0] single_timeout_ticks;
  } cfg_t;

endpackage

// ----- hdl/bgc_cfg_regs.sv -----
// Configuration register bank of the button gesture classifier.
// Depends on bgc_pkg for register indexes, reset values and cfg_t.
module bgc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [bgc_pkg::CfgIdxWidth-1:0]  wr_index_i,
  input  logic [bgc_pkg::CfgDataWidth-1:0] wr_data_i,
  output bgc_pkg::cfg_t                    cfg_o
);
  import bgc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        RegEnable:        cfg_d.enable               = wr_data_i[0];
        RegLongPress:     cfg_d.long_press_ticks     = wr_data_i[ThreshWidth-1:0];
        RegDoubleClick:   cfg_d.double_click_ticks   = wr_data_i[ThreshWidth-1:0];
        RegSingleTimeout: cfg_d.single_timeout_ticks = wr_data_i[ThreshWidth-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable               <= 1'b0;
      cfg_q.long_press_ticks     <= LongPressReset;
      cfg_q.double_click_ticks   <= DoubleClickReset;
      cfg_q.single_timeout_ticks <= SingleTimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/bgc_core.sv -----
// Gesture state and classification logic: one sample per step strobe.
// Depends on bgc_pkg for the event codes and cfg_t.
module bgc_core #(
  parameter int unsigned TickWidth = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   level_i,
  input  logic [TickWidth-1:0]   now_i,
  input  bgc_pkg::cfg_t          cfg_i,
  output bgc_pkg::key_event_e    event_o
);
  import bgc_pkg::*;

  logic                 prev_level_q, prev_level_d;
  logic                 awaiting_q, awaiting_d;
  logic                 long_rep_q, long_rep_d;
  logic [1:0]           click_cnt_q, click_cnt_d;
  logic [TickWidth-1:0] press_time_q, press_time_d;
  logic [TickWidth-1:0] rel_time_q, rel_time_d;

  logic [TickWidth-1:0] since_press, since_rel;
  logic [TickWidth-1:0] long_thr, dbl_thr, single_thr;
  logic                 long_hit;
  key_event_e           ev;

  // Differences wrap modulo 2^TickWidth.
  assign since_press = now_i - press_time_q;
  assign since_rel   = now_i - rel_time_q;
  assign long_thr    = TickWidth'(cfg_i.long_press_ticks);
  assign dbl_thr     = TickWidth'(cfg_i.double_click_ticks);
  assign single_thr  = TickWidth'(cfg_i.single_timeout_ticks);
  assign long_hit    = since_press >= long_thr;

  always_comb begin
    prev_level_d = prev_level_q;
    awaiting_d   = awaiting_q;
    long_rep_d   = long_rep_q;
    click_cnt_d  = click_cnt_q;
    press_time_d = press_time_q;
    rel_time_d   = rel_time_q;
    ev           = EvNone;

    if (level_i && !prev_level_q) begin
      // Press edge starts timing and never reports anything.
      prev_level_d = 1'b1;
      press_time_d = now_i;
      awaiting_d   = 1'b1;
      long_rep_d   = 1'b0;
    end else if (!level_i && prev_level_q) begin
      prev_level_d = 1'b0;
      awaiting_d   = 1'b0;
      if (long_rep_q) begin
        long_rep_d = 1'b0;
      end else if (long_hit) begin
        ev = EvLong;
      end else if (click_cnt_q == 2'd0) begin
        click_cnt_d = 2'd1;
        rel_time_d  = now_i;
      end else if (since_rel < dbl_thr) begin
        click_cnt_d = 2'd0;
        ev          = EvDouble;
      end else begin
        // Second click came too late: report the first, keep the second pending.
        click_cnt_d = 2'd1;
        rel_time_d  = now_i;
        ev          = EvSingle;
      end
    end else if (level_i && awaiting_q && !long_rep_q && long_hit) begin
      long_rep_d = 1'b1;
      awaiting_d = 1'b0;
      ev         = EvLong;
    end else if (click_cnt_q == 2'd1 && since_rel > single_thr) begin
      click_cnt_d = 2'd0;
      ev          = EvSingle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b0;
      awaiting_q   <= 1'b0;
      long_rep_q   <= 1'b0;
      click_cnt_q  <= 2'd0;
      press_time_q <= '0;
      rel_time_q   <= '0;
    end else if (step_i && cfg_i.enable) begin
      prev_level_q <= prev_level_d;
      awaiting_q   <= awaiting_d;
      long_rep_q   <= long_rep_d;
      click_cnt_q  <= click_cnt_d;
      press_time_q <= press_time_d;
      rel_time_q   <= rel_time_d;
    end
  end

  assign event_o = cfg_i.enable ? ev : EvNone;

endmodule

// ----- hdl/button_gesture_classifier.sv -----
// Top level of the button gesture classifier.
// Depends on bgc_pkg, bgc_cfg_regs and bgc_core.
//
// The block takes one poll sample of a button per word (the pressed level and
// a free-running tick timestamp) and returns exactly one word per sample with
// a gesture event: none, single click, long press or double click. A press
// that is held for long_press_ticks reports a long press once, either while
// still held or at release; a release that follows the previous release by
// less than double_click_ticks is a double click; a lone click whose release
// is more than single_timeout_ticks old is reported as a single click on a
// later sample. All time differences wrap modulo 2^TickWidth, so the timestamp
// may roll over freely. With enable cleared every sample gives no event and
// the gesture state is frozen. A sample is taken into an input register, is
// classified by a short path of two tick subtractions and compares against
// the gesture state, and lands in an output register; the block therefore
// accepts one sample every clock cycle while the output side does not stall,
// and each result passes through the input register and then the output
// register before it is shown. This rate is set by the update of the gesture
// state, which each sample must see from its predecessor. Configuration
// writes are always ready and must only be issued while no sample is in
// flight.
module button_gesture_classifier #(
  parameter int unsigned TickWidth = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Sample channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             key_level_i,
  input  logic [31:0]                      now_tick_i,
  // Event channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       key_event_o,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bgc_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [bgc_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import bgc_pkg::*;

  cfg_t                 cfg;
  key_event_e           core_event;

  // Input register.
  logic                 s1_valid_q;
  logic                 level_q;
  logic [TickWidth-1:0] tick_q;

  // Output register.
  logic                 out_valid_q;
  logic [1:0]           event_q;

  logic                 in_accept;
  logic                 advance;

  // The sample in the input register moves on whenever the output register
  // is empty or is being emptied in this cycle.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  bgc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  bgc_core #(
    .TickWidth (TickWidth)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .level_i (level_q),
    .now_i   (tick_q),
    .cfg_i   (cfg),
    .event_o (core_event)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Only the low TickWidth bits of the timestamp take part; a TickWidth above 32
  // zero extends the 32-bit timestamp.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      level_q <= key_level_i;
      tick_q  <= TickWidth'(now_tick_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= core_event;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_event_o = event_q;

endmodule

// ----- hdl/bgc_checker.sv -----
// Port-level checks for the button gesture classifier, bound to its top level.
// Depends only on the handshake and event ports of the top level.
module bgc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] key_event_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o
);

  // The sample side only backs up when a finished word is waiting downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("sample channel stalled with no word held at the output");

  // A word newly shown at the output comes from a sample that was accepted and passed through the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("event word appeared without a matching sample");

  // A stalled event word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(key_event_o)))
    else $error("stalled event word changed or was dropped");

  // Configuration writes are never held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write was refused");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (.*);
